>>> design/psol_pkg.sv
// Shared types and constants for the prefix/suffix overlap block.
// No dependencies; imported by psol_ram users and the top level.
package psol_pkg;

    localparam int MAX_LEN = 1024;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);
    localparam int BYTE_W  = 8;
    localparam int OVL_W   = 11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_PI_RDI,
        S_PI_RDK,
        S_PI_CMP,
        S_PI_FB,
        S_TX_RDC,
        S_TX_RDQ,
        S_TX_CMP,
        S_TX_FB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              has_char;
        logic              part;
        logic              finish;
    } item_t;

    typedef struct packed {
        logic [OVL_W-1:0] overlap_len;
        logic             overflow;
    } result_t;

endpackage

>>> design/psol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psol_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/prefix_suffix_overlap_length.sv
// Top level: loads pattern and text bytes, then finds the longest text suffix
// that equals a pattern prefix. Depends on psol_pkg and psol_ram.
//
// Usage:
//   item channel (item_valid / item_stall / item): one beat per cycle while
//   item_stall is low. A beat with has_char appends char_byte to the pattern
//   (part 0) or the text (part 1); bytes past MAX_LEN per part are dropped
//   and flag overflow. A beat with finish starts the search; item_stall stays
//   high until the result is loaded into the output register.
//   result channel (result_valid / result_stall / result): one beat per
//   finishing item, held in an output register while the receiver stalls.
//   Loading beats are taken while a result waits.
//   Search, p pattern and t text bytes: a prefix-function pass over the
//   pattern, then a match pass over the text, with at most p + t
//   failure-link steps in all. Empty pattern or text gives 0.
//   Reset clears counts, overflow flag, sequencer and result valid; RAM
//   contents are undefined and only entries below the counts are used.
module prefix_suffix_overlap_length (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  psol_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output psol_pkg::result_t result
);
    import psol_pkg::*;

    state_t            state_reg, state_next;
    logic [CW-1:0]     p_cnt_reg, p_cnt_next;
    logic [CW-1:0]     t_cnt_reg, t_cnt_next;
    logic              drop_reg, drop_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     q_reg, q_next;
    logic [BYTE_W-1:0] cur_reg, cur_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              item_accept;
    logic              pat_we, txt_we;
    logic [AW-1:0]     pat_raddr, txt_raddr;
    logic [BYTE_W-1:0] pat_rdata, txt_rdata;
    logic              fail_we;
    logic [AW-1:0]     fail_waddr, fail_wdata, fail_raddr, fail_rdata;
    logic [CW-1:0]     i_inc, j_inc;
    logic              eq;
    logic              match;

    assign item_accept  = item_valid && !item_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign pat_we = item_accept && item.has_char && !item.part
                    && (p_cnt_reg < CW'(MAX_LEN));
    assign txt_we = item_accept && item.has_char && item.part
                    && (t_cnt_reg < CW'(MAX_LEN));

    assign i_inc = i_reg + 1'b1;
    assign j_inc = j_reg + 1'b1;
    assign eq    = (pat_rdata == cur_reg);
    assign match = (q_reg < p_cnt_reg) && eq;

    psol_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (p_cnt_reg[AW-1:0]),
        .wdata (item.char_byte),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    psol_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_txt_ram (
        .clk   (clk),
        .we    (txt_we),
        .waddr (t_cnt_reg[AW-1:0]),
        .wdata (item.char_byte),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    psol_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_fail_ram (
        .clk   (clk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            p_cnt_reg        <= '0;
            t_cnt_reg        <= '0;
            drop_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            p_cnt_reg        <= p_cnt_next;
            t_cnt_reg        <= t_cnt_next;
            drop_reg         <= drop_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        q_reg      <= q_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        p_cnt_next        = p_cnt_reg;
        t_cnt_next        = t_cnt_reg;
        drop_next         = drop_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        j_next            = j_reg;
        q_next            = q_reg;
        cur_next          = cur_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        pat_raddr         = '0;
        txt_raddr         = '0;
        fail_we           = 1'b0;
        fail_waddr        = '0;
        fail_wdata        = '0;
        fail_raddr        = '0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (pat_we)
                    begin
                        p_cnt_next = p_cnt_reg + 1'b1;
                    end
                    if (txt_we)
                    begin
                        t_cnt_next = t_cnt_reg + 1'b1;
                    end
                    if (item.has_char && !pat_we && !txt_we)
                    begin
                        drop_next = 1'b1;
                    end
                    if (item.finish)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                fail_we    = 1'b1;
                fail_waddr = '0;
                fail_wdata = '0;
                i_next     = CW'(1);
                k_next     = '0;
                j_next     = '0;
                q_next     = '0;
                if (p_cnt_reg == '0 || t_cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (p_cnt_reg > CW'(1))
                begin
                    state_next = S_PI_RDI;
                end
                else
                begin
                    state_next = S_TX_RDC;
                end
            end
            S_PI_RDI:
            begin
                pat_raddr  = i_reg[AW-1:0];
                state_next = S_PI_RDK;
            end
            S_PI_RDK:
            begin
                cur_next   = pat_rdata;
                pat_raddr  = k_reg;
                state_next = S_PI_CMP;
            end
            S_PI_CMP:
            begin
                if (!eq && k_reg != '0)
                begin
                    fail_raddr = k_reg - 1'b1;
                    state_next = S_PI_FB;
                end
                else
                begin
                    fail_we    = 1'b1;
                    fail_waddr = i_reg[AW-1:0];
                    fail_wdata = k_reg + AW'(eq);
                    k_next     = k_reg + AW'(eq);
                    i_next     = i_inc;
                    if (i_inc < p_cnt_reg)
                    begin
                        state_next = S_PI_RDI;
                    end
                    else
                    begin
                        state_next = S_TX_RDC;
                    end
                end
            end
            S_PI_FB:
            begin
                k_next     = fail_rdata;
                pat_raddr  = fail_rdata;
                state_next = S_PI_CMP;
            end
            S_TX_RDC:
            begin
                txt_raddr  = j_reg[AW-1:0];
                state_next = S_TX_RDQ;
            end
            S_TX_RDQ:
            begin
                cur_next   = txt_rdata;
                pat_raddr  = q_reg[AW-1:0];
                state_next = S_TX_CMP;
            end
            S_TX_CMP:
            begin
                if (!match && q_reg != '0)
                begin
                    fail_raddr = AW'(q_reg - 1'b1);
                    state_next = S_TX_FB;
                end
                else
                begin
                    q_next = q_reg + CW'(match);
                    j_next = j_inc;
                    if (j_inc < t_cnt_reg)
                    begin
                        state_next = S_TX_RDC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_TX_FB:
            begin
                q_next     = CW'(fail_rdata);
                pat_raddr  = fail_rdata;
                state_next = S_TX_CMP;
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.overlap_len = OVL_W'(q_reg);
                    result_next.overflow    = drop_reg;
                    result_valid_next       = 1'b1;
                    p_cnt_next              = '0;
                    t_cnt_next              = '0;
                    drop_next               = 1'b0;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_pi_k_below_i: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PI_CMP |-> CW'(k_reg) < i_reg)
        else $error("prefix-function length not below position");

    a_tx_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TX_CMP |-> q_reg <= p_cnt_reg)
        else $error("text match state exceeds pattern length");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE)
        |=> (p_cnt_reg == '0 && t_cnt_reg == '0 && !drop_reg && result_valid_reg))
        else $error("finish did not clear counts or post result");

endmodule

>>> tb/prefix_suffix_overlap_length_test.sv
// Self-checking bench for prefix_suffix_overlap_length: directed and random pattern/text pairs
// with gaps and stalls on both channels, checked beat by beat against a suffix-match predictor.
// Depends on psol_pkg and the design sources only.
`timescale 1ns / 100ps

module prefix_suffix_overlap_length_test;
    import psol_pkg::*;

    localparam bit PART_PATTERN = 1'b0;
    localparam bit PART_TEXT    = 1'b1;
    localparam int IDLE_LIMIT   = 50000;
    localparam int RANDOM_ITEMS = 1880;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 200;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    item_t      stim_q [$];
    logic [7:0] pat_q [$];
    logic [7:0] txt_q [$];
    logic [7:0] sym [3];
    result_t    overlap_due [$];
    result_t    due_beat;

    logic [7:0] pattern_bytes [MAX_LEN];
    logic [7:0] text_bytes [MAX_LEN];
    int         pattern_len   = 0;
    int         text_len      = 0;
    bit         bytes_dropped = 1'b0;

    int loaded_items = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int errors       = 0;
    int idle_cycles  = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    bit tx_calm      = 1'b0;
    bit rx_calm      = 1'b0;
    bit item_fire    = 1'b0;
    bit hold_off     = 1'b0;

    prefix_suffix_overlap_length u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte(input int alpha);
        if (alpha >= 256)
            return 8'($urandom_range(0, 255));
        return sym[$urandom_range(0, alpha - 1)];
    endfunction

    // longest text suffix equal to a pattern prefix, no longer than either string
    function automatic int overlap_of();
        int cap;
        int k;
        int j;
        bit same;
        cap = (pattern_len < text_len) ? pattern_len : text_len;
        for (k = cap; k > 0; k--)
        begin
            same = 1'b1;
            for (j = 0; j < k; j++)
            begin
                if (pattern_bytes[j] != text_bytes[text_len - k + j])
                begin
                    same = 1'b0;
                    break;
                end
            end
            if (same)
                return k;
        end
        return 0;
    endfunction

    task automatic absorb_item(input item_t it);
        result_t want;
        if (it.has_char)
        begin
            if (it.part == PART_TEXT)
            begin
                if (text_len < MAX_LEN)
                begin
                    text_bytes[text_len] = it.char_byte;
                    text_len++;
                end
                else
                    bytes_dropped = 1'b1;
            end
            else
            begin
                if (pattern_len < MAX_LEN)
                begin
                    pattern_bytes[pattern_len] = it.char_byte;
                    pattern_len++;
                end
                else
                    bytes_dropped = 1'b1;
            end
        end
        if (it.finish)
        begin
            want.overlap_len = OVL_W'(overlap_of());
            want.overflow    = bytes_dropped;
            overlap_due.push_back(want);
            pattern_len   = 0;
            text_len      = 0;
            bytes_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    // drain pat_q and txt_q into beats, parts interleaved at random
    task automatic emit_pair(input bit fin_carries_byte, input int noise_pct);
        item_t it;
        int    n;
        n = pat_q.size() + txt_q.size();
        while (pat_q.size() + txt_q.size() > 0)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                it.char_byte = 8'($urandom_range(0, 255));
                it.has_char  = 1'b0;
                it.part      = 1'($urandom_range(0, 1));
                it.finish    = 1'b0;
                stim_q.push_back(it);
                loaded_items++;
            end
            it.has_char = 1'b1;
            it.finish   = 1'b0;
            if (txt_q.size() == 0 || (pat_q.size() != 0 && $urandom_range(0, 1) == 0))
            begin
                it.part      = PART_PATTERN;
                it.char_byte = pat_q.pop_front();
            end
            else
            begin
                it.part      = PART_TEXT;
                it.char_byte = txt_q.pop_front();
            end
            if (fin_carries_byte && pat_q.size() + txt_q.size() == 0)
                it.finish = 1'b1;
            stim_q.push_back(it);
            loaded_items++;
        end
        if (!fin_carries_byte || n == 0)
        begin
            it.char_byte = 8'($urandom_range(0, 255));
            it.has_char  = 1'b0;
            it.part      = 1'($urandom_range(0, 1));
            it.finish    = 1'b1;
            stim_q.push_back(it);
            loaded_items++;
        end
    endtask

    task automatic build_random_pair();
        int kind;
        int alpha;
        int r;
        int plen;
        int tlen;
        int junk;
        int k;
        int period;
        int offset;
        int i;
        for (i = 0; i < 3; i++)
            sym[i] = 8'($urandom_range(0, 255));
        r     = $urandom_range(0, 9);
        alpha = (r < 5) ? 2 : (r < 8) ? 3 : 256;
        kind  = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            plen = $urandom_range(1, 12);
            for (i = 0; i < plen; i++)
                pat_q.push_back(pick_byte(alpha));
            junk = $urandom_range(0, 8);
            for (i = 0; i < junk; i++)
                txt_q.push_back(pick_byte(alpha));
            k = $urandom_range(0, plen);
            for (i = 0; i < k; i++)
                txt_q.push_back(pat_q[i]);
        end
        else if (kind == 6)
        begin
            period = $urandom_range(1, 3);
            offset = $urandom_range(0, 2);
            plen   = $urandom_range(1, 16);
            tlen   = $urandom_range(1, 20);
            for (i = 0; i < plen; i++)
                pat_q.push_back(sym[i % period]);
            for (i = 0; i < tlen; i++)
                txt_q.push_back(sym[(i + offset) % period]);
        end
        else if (kind == 7)
        begin
            r    = $urandom_range(0, 2);
            plen = $urandom_range(1, 6);
            for (i = 0; i < plen; i++)
            begin
                if (r == 0)
                    pat_q.push_back(pick_byte(alpha));
                else if (r == 1)
                    txt_q.push_back(pick_byte(alpha));
            end
        end
        else
        begin
            plen = $urandom_range(0, 60);
            tlen = $urandom_range(0, 60);
            for (i = 0; i < plen; i++)
                pat_q.push_back(pick_byte(alpha));
            for (i = 0; i < tlen; i++)
                txt_q.push_back(pick_byte(alpha));
        end
    endtask

    // driver: hold a stalled beat, otherwise insert a gap or offer the next one
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                tx_calm = !tx_calm;
            if (!item_valid || item_fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (stim_q.size() > 0)
                begin
                    item       <= stim_q.pop_front();
                    item_valid <= 1'b1;
                    gap_left = tx_calm ? 0 : pick_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            if (stall_left == 0)
                stall_left = rx_calm ? 0 : pick_gap();
            else
                stall_left--;
            result_stall <= hold_off || (stall_left != 0);
        end
    end

    // long receiver hold-off so the block backs up into the item channel
    initial
    begin
        while (results_seen < 40)
            @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_fire <= 1'b0;
        else
        begin
            item_fire <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                absorb_item(item);
                items_taken++;
            end
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (overlap_due.size() == 0)
                    report_mismatch("overlap_len of a beat with none due",
                                    int'(result.overlap_len), -1);
                else
                begin
                    due_beat = overlap_due.pop_front();
                    if (result.overlap_len !== due_beat.overlap_len)
                        report_mismatch("overlap_len", int'(result.overlap_len),
                                        int'(due_beat.overlap_len));
                    if (result.overflow !== due_beat.overflow)
                        report_mismatch("overflow", int'(result.overflow),
                                        int'(due_beat.overflow));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int directed_items;
        int prefix_len;
        int i;
        bit big_done;
        logic [7:0] b;

        emit_pair(1'b0, 0);
        pat_q = '{8'h00};
        emit_pair(1'b0, 0);
        pat_q = '{8'hFF};
        txt_q = '{8'hFF};
        emit_pair(1'b1, 0);
        pat_q = '{8'h00, 8'hFF, 8'h00};
        txt_q = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        emit_pair(1'b1, 0);
        pat_q = '{8'hAA, 8'h55};
        txt_q = '{8'h55, 8'hAA};
        emit_pair(1'b0, 0);
        pat_q = '{8'h12, 8'h34};
        txt_q = '{8'h56};
        emit_pair(1'b0, 0);
        directed_items = loaded_items;

        big_done = 1'b0;
        while (loaded_items - directed_items < RANDOM_ITEMS)
        begin
            if (!big_done && loaded_items - directed_items >= RANDOM_ITEMS - MAX_LEN - 100)
            begin
                // fill the pattern one byte past full, text a short pattern prefix
                for (i = 0; i <= MAX_LEN; i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    pat_q.push_back(b);
                end
                prefix_len = $urandom_range(1, 16);
                for (i = 0; i < prefix_len; i++)
                    txt_q.push_back(pat_q[i]);
                emit_pair(1'($urandom_range(0, 1)), 2);
                big_done = 1'b1;
            end
            build_random_pair();
            emit_pair($urandom_range(0, 3) == 0, 6);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < stim_q.size() + items_taken && stim_q.size() != 0)
            @(negedge clk);
        while (item_valid)
            @(negedge clk);
        while (overlap_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
design/psol_pkg.sv
design/psol_ram.sv
design/prefix_suffix_overlap_length.sv
tb/prefix_suffix_overlap_length_test.sv
